// ===== design/sds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_pkg: shared definitions for the SCAN disk scheduler
// Sizes of the request store, field widths, operation codes and the
// result type of the shared compare unit.
// ----------------------------------------------------------------------------
package sds_pkg;

  localparam int MAX_REQUESTS = 32;
  localparam int CNT_W        = $clog2(MAX_REQUESTS + 1);
  localparam int ADDR_W       = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int TRACK_W      = 16;
  localparam int SEEK_W       = 17;

  localparam logic [TRACK_W-1:0] UPPER_END_RESET = '1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic gt;      // data above the threshold
    logic lt;      // data below the threshold
    logic better;  // data closer to the threshold than the current best
    logic equal;   // data equal to the current best
  } cmp_res_t;

endpackage

// ===== design/scan_disk_scheduler.sv =====
`timescale 1ns / 1ps
// A load is written to the store; a rejected load shows its overflow result in the next cycle.
// A start first counts the stored requests above and below the start head, then searches the store
// once for each distinct track it stops at, all through the one compare unit.
// Loads are accepted one per cycle while the result channel is not stalled;
// a run holds off input until its last stop is issued.
// rst_n is synchronous and active low: it empties the store and sets upper_end to 65535.
// ----------------------------------------------------------------------------
// scan_disk_scheduler: SCAN elevator disk scheduler
// Stores pending request tracks and, on a start transaction, serves those off the start head
// track in elevator order, emitting each stop with the running seek total.
// ----------------------------------------------------------------------------
module scan_disk_scheduler (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_operation,
  input  logic [sds_pkg::TRACK_W-1:0] in_request_track,
  input  logic [sds_pkg::TRACK_W-1:0] in_start_head,
  input  logic                        in_sweep_up,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [sds_pkg::TRACK_W-1:0] out_served_track,
  output logic [sds_pkg::SEEK_W-1:0]  out_seek_total,
  output logic                        out_is_last,
  output logic                        out_overflow,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sds_pkg::TRACK_W-1:0] cfg_upper_end
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_CNT  = 3'd1;
  localparam logic [2:0] ST_FIND = 3'd2;
  localparam logic [2:0] ST_EMIT = 3'd3;
  localparam logic [2:0] ST_TURN = 3'd4;

  logic [2:0]                  state_r, state_nxt;
  logic [sds_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [sds_pkg::CNT_W-1:0]   idx_r, idx_nxt;
  logic                        pvld_r, pvld_nxt;
  logic [sds_pkg::CNT_W-1:0]   cnt_hi_r, cnt_hi_nxt;
  logic [sds_pkg::CNT_W-1:0]   cnt_lo_r, cnt_lo_nxt;
  logic [sds_pkg::CNT_W-1:0]   rem_r, rem_nxt;
  logic [sds_pkg::CNT_W-1:0]   rem_b_r, rem_b_nxt;
  logic [sds_pkg::CNT_W-1:0]   grp_r, grp_nxt;
  logic                        found_r, found_nxt;
  logic                        phase_b_r, phase_b_nxt;
  logic                        asc_r, asc_nxt;
  logic                        up_r, up_nxt;
  logic [sds_pkg::TRACK_W-1:0] upper_r, upper_nxt;
  logic [sds_pkg::TRACK_W-1:0] head_r, head_nxt;
  logic [sds_pkg::TRACK_W-1:0] thr_r, thr_nxt;
  logic [sds_pkg::TRACK_W-1:0] best_r, best_nxt;
  logic [sds_pkg::TRACK_W-1:0] pos_r, pos_nxt;
  logic [sds_pkg::SEEK_W-1:0]  acc_r, acc_nxt;

  logic                        out_valid_r, out_valid_nxt;
  logic [sds_pkg::TRACK_W-1:0] out_track_r, out_track_nxt;
  logic [sds_pkg::SEEK_W-1:0]  out_seek_r, out_seek_nxt;
  logic                        out_last_r, out_last_nxt;
  logic                        out_ovf_r, out_ovf_nxt;

  logic                        out_free;
  logic                        in_acc;
  logic                        scan_done;
  logic                        wr_en;
  logic [sds_pkg::TRACK_W-1:0] rd_data;
  logic [sds_pkg::TRACK_W-1:0] seek_tgt;
  logic [sds_pkg::SEEK_W-1:0]  seek_sum;
  sds_pkg::cmp_res_t           cmp;

  sds_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_r[sds_pkg::ADDR_W-1:0]),
    .wr_data (in_request_track),
    .rd_addr (idx_r[sds_pkg::ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  sds_cmp u_cmp (
    .data (rd_data),
    .thr  (thr_r),
    .best (best_r),
    .asc  (asc_r),
    .res  (cmp)
  );

  // The turning stop goes to the upper end or to track 0.
  assign seek_tgt = (state_r == ST_TURN) ? (up_r ? upper_r : '0) : best_r;

  sds_seek u_seek (
    .acc     (acc_r),
    .pos     (pos_r),
    .target  (seek_tgt),
    .acc_nxt (seek_sum)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = !((state_r == ST_IDLE) && out_free);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = (state_r == ST_IDLE);
  assign wr_en     = in_acc && (in_operation == sds_pkg::OP_LOAD) &&
                     (cnt_r < sds_pkg::CNT_W'(sds_pkg::MAX_REQUESTS));
  // A scan is over once every address has been issued and the last read consumed.
  assign scan_done = (idx_r == cnt_r) && !pvld_r;

  assign out_valid        = out_valid_r;
  assign out_served_track = out_track_r;
  assign out_seek_total   = out_seek_r;
  assign out_is_last      = out_last_r;
  assign out_overflow     = out_ovf_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pvld_nxt      = pvld_r;
    cnt_hi_nxt    = cnt_hi_r;
    cnt_lo_nxt    = cnt_lo_r;
    rem_nxt       = rem_r;
    rem_b_nxt     = rem_b_r;
    grp_nxt       = grp_r;
    found_nxt     = found_r;
    phase_b_nxt   = phase_b_r;
    asc_nxt       = asc_r;
    up_nxt        = up_r;
    upper_nxt     = upper_r;
    head_nxt      = head_r;
    thr_nxt       = thr_r;
    best_nxt      = best_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r;
    out_track_nxt = out_track_r;
    out_seek_nxt  = out_seek_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_valid && cfg_ready) begin
      upper_nxt = cfg_upper_end;
    end

    // Store walk shared by the count pass and the search pass.
    if ((state_r == ST_CNT) || (state_r == ST_FIND)) begin
      if (idx_r < cnt_r) begin
        idx_nxt  = idx_r + 1'b1;
        pvld_nxt = 1'b1;
      end else begin
        pvld_nxt = 1'b0;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_operation == sds_pkg::OP_LOAD) begin
            if (wr_en) begin
              cnt_nxt = cnt_r + 1'b1;
            end else begin
              out_valid_nxt = 1'b1;
              out_track_nxt = '0;
              out_seek_nxt  = '0;
              out_last_nxt  = 1'b0;
              out_ovf_nxt   = 1'b1;
            end
          end else begin
            head_nxt    = in_start_head;
            thr_nxt     = in_start_head;
            pos_nxt     = in_start_head;
            up_nxt      = in_sweep_up;
            acc_nxt     = '0;
            idx_nxt     = '0;
            pvld_nxt    = 1'b0;
            cnt_hi_nxt  = '0;
            cnt_lo_nxt  = '0;
            phase_b_nxt = 1'b0;
            state_nxt   = ST_CNT;
          end
        end
      end
      ST_CNT: begin
        if (pvld_r) begin
          if (cmp.gt) cnt_hi_nxt = cnt_hi_r + 1'b1;
          if (cmp.lt) cnt_lo_nxt = cnt_lo_r + 1'b1;
        end
        if (scan_done) begin
          asc_nxt   = up_r;
          rem_nxt   = up_r ? cnt_hi_r : cnt_lo_r;
          rem_b_nxt = up_r ? cnt_lo_r : cnt_hi_r;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = ((up_r ? cnt_hi_r : cnt_lo_r) != '0) ? ST_FIND : ST_TURN;
        end
      end
      ST_FIND: begin
        // Nearest track beyond the threshold in the sweep direction, with its copies.
        if (pvld_r && (asc_r ? cmp.gt : cmp.lt)) begin
          if (!found_r || cmp.better) begin
            best_nxt  = rd_data;
            grp_nxt   = sds_pkg::CNT_W'(1);
            found_nxt = 1'b1;
          end else if (cmp.equal) begin
            grp_nxt = grp_r + 1'b1;
          end
        end
        if (scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_track_nxt = best_r;
          out_seek_nxt  = seek_sum;
          out_last_nxt  = phase_b_r && (rem_r == sds_pkg::CNT_W'(1));
          out_ovf_nxt   = 1'b0;
          acc_nxt       = seek_sum;
          pos_nxt       = best_r;
          grp_nxt       = grp_r - 1'b1;
          rem_nxt       = rem_r - 1'b1;
          if (grp_r == sds_pkg::CNT_W'(1)) begin
            thr_nxt = best_r;
            if (rem_r == sds_pkg::CNT_W'(1)) begin
              if (phase_b_r) begin
                cnt_nxt   = '0;
                state_nxt = ST_IDLE;
              end else begin
                state_nxt = ST_TURN;
              end
            end else begin
              idx_nxt   = '0;
              pvld_nxt  = 1'b0;
              found_nxt = 1'b0;
              state_nxt = ST_FIND;
            end
          end
        end
      end
      ST_TURN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_track_nxt = seek_tgt;
          out_seek_nxt  = seek_sum;
          out_last_nxt  = (rem_b_r == '0);
          out_ovf_nxt   = 1'b0;
          acc_nxt       = seek_sum;
          pos_nxt       = seek_tgt;
          phase_b_nxt   = 1'b1;
          rem_nxt       = rem_b_r;
          thr_nxt       = head_r;
          asc_nxt       = !up_r;
          if (rem_b_r != '0) begin
            idx_nxt   = '0;
            pvld_nxt  = 1'b0;
            found_nxt = 1'b0;
            state_nxt = ST_FIND;
          end else begin
            cnt_nxt   = '0;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      pvld_r      <= 1'b0;
      upper_r     <= sds_pkg::UPPER_END_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pvld_r      <= pvld_nxt;
      upper_r     <= upper_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_hi_r    <= cnt_hi_nxt;
    cnt_lo_r    <= cnt_lo_nxt;
    rem_r       <= rem_nxt;
    rem_b_r     <= rem_b_nxt;
    grp_r       <= grp_nxt;
    found_r     <= found_nxt;
    phase_b_r   <= phase_b_nxt;
    asc_r       <= asc_nxt;
    up_r        <= up_nxt;
    head_r      <= head_nxt;
    thr_r       <= thr_nxt;
    best_r      <= best_nxt;
    pos_r       <= pos_nxt;
    acc_r       <= acc_nxt;
    out_track_r <= out_track_nxt;
    out_seek_r  <= out_seek_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

endmodule

// ===== design/sds_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_store: request track memory
// One write port and one registered read port.
// ----------------------------------------------------------------------------
module sds_store (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [sds_pkg::ADDR_W-1:0]    wr_addr,
  input  logic [sds_pkg::TRACK_W-1:0]   wr_data,
  input  logic [sds_pkg::ADDR_W-1:0]    rd_addr,
  output logic [sds_pkg::TRACK_W-1:0]   rd_data
);

  logic [sds_pkg::TRACK_W-1:0] mem [sds_pkg::MAX_REQUESTS];
  logic [sds_pkg::TRACK_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/sds_cmp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_cmp: shared track compare unit
// Compares one stored track against the search threshold and the best
// candidate found so far in the current scan.
// ----------------------------------------------------------------------------
module sds_cmp (
  input  logic [sds_pkg::TRACK_W-1:0] data,
  input  logic [sds_pkg::TRACK_W-1:0] thr,
  input  logic [sds_pkg::TRACK_W-1:0] best,
  input  logic                        asc,
  output sds_pkg::cmp_res_t           res
);

  always_comb begin
    res.gt     = data > thr;
    res.lt     = data < thr;
    res.better = asc ? (data < best) : (data > best);
    res.equal  = data == best;
  end

endmodule

// ===== design/sds_seek.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_seek: seek distance accumulator
// Adds the absolute head movement to the running total, saturating at the
// largest value the total can hold.
// ----------------------------------------------------------------------------
module sds_seek (
  input  logic [sds_pkg::SEEK_W-1:0]  acc,
  input  logic [sds_pkg::TRACK_W-1:0] pos,
  input  logic [sds_pkg::TRACK_W-1:0] target,
  output logic [sds_pkg::SEEK_W-1:0]  acc_nxt
);

  logic [sds_pkg::TRACK_W-1:0] diff;
  logic [sds_pkg::SEEK_W:0]    sum;

  always_comb begin
    diff = (pos >= target) ? (pos - target) : (target - pos);
    sum  = {1'b0, acc} + {{(sds_pkg::SEEK_W + 1 - sds_pkg::TRACK_W){1'b0}}, diff};
    acc_nxt = sum[sds_pkg::SEEK_W] ? '1 : sum[sds_pkg::SEEK_W-1:0];
  end

endmodule

// ===== design/sds_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sds_checker: port-level checks for the SCAN disk scheduler
// Watches the top-level ports and is bound to every instance of it.
// ----------------------------------------------------------------------------
module sds_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [sds_pkg::TRACK_W-1:0] out_served_track,
  input logic [sds_pkg::SEEK_W-1:0]  out_seek_total,
  input logic                        out_is_last,
  input logic                        out_overflow
);

  // Reset leaves no transaction pending on the result channel.
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A dropped-load result carries nothing but the overflow flag.
  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |->
      !out_is_last && (out_served_track == '0) && (out_seek_total == '0))
    else $error("overflow result with nonzero payload");

  // While a run still has stops to give, no new input transaction is taken.
  a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_overflow && !out_is_last |-> in_stall)
    else $error("input accepted in the middle of a run");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_served_track) && $stable(out_seek_total))
    else $error("stalled result changed");

endmodule

bind scan_disk_scheduler sds_checker u_sds_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_served_track (out_served_track),
  .out_seek_total   (out_seek_total),
  .out_is_last      (out_is_last),
  .out_overflow     (out_overflow)
);
